/* rtl/core/stil_pkg.sv */
// ----------------------------------------------------------------------------
// Symbol table package
// Shared types, sizes and codes for the symbol table insert and lookup block.
// ----------------------------------------------------------------------------
package stil_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int NAME_W  = 72;
    localparam int ADDR_W  = 16;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_HIT       = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISS      = 3'd4;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic              op;
        logic [63:0]       key_lo;
        logic [7:0]        key_hi;
        logic [ADDR_W-1:0] address;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [ADDR_W-1:0] found_address;
    } t_out;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   idx;
        t_entry entry;
    } t_wr_req;

    typedef struct packed {
        logic en;
        t_idx idx;
    } t_rd_req;

endpackage

/* rtl/core/stil_store.sv */
// ----------------------------------------------------------------------------
// Symbol table entry store
// One write port and one registered read port over the name and address table.
// ----------------------------------------------------------------------------
module stil_store (
    input  logic             i_clk,
    input  stil_pkg::t_wr_req i_wr,
    input  stil_pkg::t_rd_req i_rd,
    output stil_pkg::t_entry  o_rd_data
);
    import stil_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/symbol_table_insert_lookup.sv */
// ----------------------------------------------------------------------------
// Symbol table insert and lookup
// Linear-search symbol table with one shared name comparator.
// ----------------------------------------------------------------------------
// Usage
//   Input beats (i_valid/o_ready) carry an operation, a nine-character name
//   split over key_lo and key_hi, and an address. Output beats
//   (o_valid/i_ready) carry a status, the entry position and an address.
//   Every input beat gives exactly one output beat, in order.
//   One beat is worked on at a time. The table memory is read one entry per
//   cycle and the registered read data feeds a single 72-bit comparator; a
//   scan stops early on a hit and otherwise covers every stored entry.
//   o_ready is high only while the block is idle.
//   Reset empties the table at once; stored names are never read beyond the
//   fill count, so no clearing pass is needed.
//   A result waits in the output register while the receiver stalls; the
//   next beat may be accepted and scanned meanwhile, and its result is held
//   back until the waiting one has been taken.
// ----------------------------------------------------------------------------
module symbol_table_insert_lookup (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  stil_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output stil_pkg::t_out o_data
);
    import stil_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state  r_state, n_state;
    t_cnt    r_count, n_count;
    t_cnt    r_idx, n_idx;
    t_idx    r_cmp_idx, n_cmp_idx;
    logic    r_pend, n_pend;
    t_in     r_in, n_in;
    t_out    r_res, n_res;
    logic    r_out_vld, n_out_vld;
    t_out    r_out, n_out;

    t_wr_req wr_req;
    t_rd_req rd_req;
    t_entry  rd_data;
    logic    match;
    logic    load_out;

    stil_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

    assign match    = r_pend && (rd_data.name == {r_in.key_hi, r_in.key_lo});
    assign load_out = (r_state == S_RESP) && (!r_out_vld || i_ready);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_idx = r_cmp_idx;
        n_pend    = r_pend;
        n_in      = r_in;
        n_res     = r_res;
        wr_req    = '0;
        rd_req    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in    = i_data;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_res.status        = (r_in.op == OP_LOOKUP) ? ST_HIT : ST_DUPLICATE;
                    n_res.position      = POS_W'(r_cmp_idx);
                    n_res.found_address = rd_data.addr;
                    n_pend              = 1'b0;
                    n_state             = S_RESP;
                end else if (r_idx < r_count) begin
                    rd_req.en  = 1'b1;
                    rd_req.idx = r_idx[IDX_W-1:0];
                    n_cmp_idx  = r_idx[IDX_W-1:0];
                    n_pend     = 1'b1;
                    n_idx      = r_idx + 1'b1;
                end else begin
                    n_pend              = 1'b0;
                    n_state             = S_RESP;
                    n_res.position      = '0;
                    n_res.found_address = '0;
                    if (r_in.op == OP_LOOKUP) begin
                        n_res.status = ST_MISS;
                    end else if (r_count >= CNT_W'(DEPTH)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        wr_req.en         = 1'b1;
                        wr_req.idx        = r_count[IDX_W-1:0];
                        wr_req.entry.name = {r_in.key_hi, r_in.key_lo};
                        wr_req.entry.addr = r_in.address;
                        n_res.status      = ST_INSERTED;
                        n_res.position    = POS_W'(r_count);
                        n_count           = r_count + 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_ready;
        if (load_out) begin
            n_out     = r_res;
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_in      <= n_in;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

/* rtl/core/stil_chk.sv */
// ----------------------------------------------------------------------------
// Symbol table port checker
// Checks on the port behaviour of the symbol table block over time.
// ----------------------------------------------------------------------------
module stil_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input stil_pkg::t_out o_data
);
    import stil_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted again while an operation is in progress");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == ST_INSERTED) || (o_data.status == ST_DUPLICATE) ||
                    (o_data.status == ST_FULL) || (o_data.status == ST_HIT) ||
                    (o_data.status == ST_MISS))
        else $error("undefined status code");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_data.status == ST_MISS) || (o_data.status == ST_FULL))
        |-> (o_data.position == '0) && (o_data.found_address == '0))
        else $error("miss or full result carries a position or address");

    a_insert_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_INSERTED) |-> (o_data.found_address == '0))
        else $error("insert result carries an address");

endmodule

bind symbol_table_insert_lookup stil_chk u_stil_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

/* dv/symtab_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Symbol table response checker
// Watches both channels of the symbol table block and keeps its own copy of
// the table. Every accepted input beat queues the response it should cause,
// and each successful insert adds to that copy. Every accepted output beat
// is compared field by field with the oldest queued response.
// ----------------------------------------------------------------------------
module symtab_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  stil_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  stil_pkg::t_out i_out_data,
    output int             o_pending,
    output int             o_fail_count
);

    import stil_pkg::*;

    logic [NAME_W-1:0] table_names [DEPTH];
    logic [ADDR_W-1:0] table_addrs [DEPTH];
    int                fill_level = 0;
    int                mismatches = 0;
    t_out              expected_responses [$];

    task automatic predict_response(input t_in beat, output t_out resp);
        logic [NAME_W-1:0] key;
        logic              hit;
        int                where;
        int                i;
        key   = {beat.key_hi, beat.key_lo};
        hit   = 1'b0;
        where = 0;
        resp  = '0;
        for (i = 0; i < fill_level; i++) begin
            if (!hit && table_names[i] == key) begin
                hit   = 1'b1;
                where = i;
            end
        end
        if (beat.op == OP_INSERT) begin
            if (hit) begin
                resp.status        = ST_DUPLICATE;
                resp.position      = where[POS_W-1:0];
                resp.found_address = table_addrs[where];
            end else if (fill_level >= DEPTH) begin
                resp.status = ST_FULL;
            end else begin
                table_names[fill_level] = key;
                table_addrs[fill_level] = beat.address;
                resp.status             = ST_INSERTED;
                resp.position           = fill_level[POS_W-1:0];
                fill_level++;
            end
        end else if (hit) begin
            resp.status        = ST_HIT;
            resp.position      = where[POS_W-1:0];
            resp.found_address = table_addrs[where];
        end else begin
            resp.status = ST_MISS;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            fill_level = 0;
            expected_responses.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_response(i_in_data, want);
                expected_responses.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_responses.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %0d %0d %h",
                             $time, i_out_data.status, i_out_data.position,
                             i_out_data.found_address);
                    mismatches++;
                end else begin
                    want = expected_responses.pop_front();
                    if (i_out_data.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_out_data.status);
                        mismatches++;
                    end
                    if (i_out_data.position !== want.position) begin
                        $display("%0t: position mismatch: expected %0d, actual %0d",
                                 $time, want.position, i_out_data.position);
                        mismatches++;
                    end
                    if (i_out_data.found_address !== want.found_address) begin
                        $display("%0t: found_address mismatch: expected %h, actual %h",
                                 $time, want.found_address, i_out_data.found_address);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_responses.size();
        o_fail_count <= mismatches;
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Symbol table insert and lookup testbench
// Drives a short directed sequence followed by random inserts and lookups
// into the symbol table, with bursty input, a patterned output stall and
// recurring long receiver hold-offs. A checker beside the block predicts and compares
// every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    import stil_pkg::*;

    localparam int TOTAL_BEATS    = 1400;
    localparam int LONG_HOLD      = 600;
    localparam int MAX_GAP        = 80;
    localparam int DRAIN_CYCLES   = DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 4 * (LONG_HOLD + MAX_GAP + DEPTH + 3);

    typedef enum int {
        SINK_FREE,
        SINK_COIN,
        SINK_PERIODIC,
        SINK_SPARSE,
        SINK_HOLD
    } t_sink_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic i_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    int                pending;
    int                fail_count;
    int                idle_cycles = 0;
    logic [NAME_W-1:0] known_names [$];

    symbol_table_insert_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    symtab_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [NAME_W-1:0] text_name(input string s);
        logic [NAME_W-1:0] name;
        int                i;
        name = '0;
        for (i = 0; i < s.len() && i < 9; i++) begin
            name[8*i +: 8] = s[i];
        end
        return name;
    endfunction

    function automatic logic [NAME_W-1:0] random_name();
        logic [NAME_W-1:0] name;
        string             alphabet;
        int                kind;
        int                len;
        int                i;
        alphabet = "abcdefghijklmnopqrstuvwxyz_0123456789";
        name     = '0;
        kind     = $urandom_range(0, 3);
        if (kind == 0) begin
            name[31:0]  = $urandom;
            name[63:32] = $urandom;
            name[71:64] = 8'($urandom_range(0, 255));
        end else begin
            len = $urandom_range(1, 9);
            for (i = 0; i < len; i++) begin
                name[8*i +: 8] = alphabet[$urandom_range(0, alphabet.len() - 1)];
            end
            if (kind == 3 && len < 8) begin
                name[8*(len+1) +: 8] = 8'($urandom_range(1, 255));
            end
        end
        return name;
    endfunction

    function automatic t_in make_beat(input logic op, input logic [NAME_W-1:0] name,
                                      input logic [ADDR_W-1:0] addr);
        t_in beat;
        beat.op                    = op;
        {beat.key_hi, beat.key_lo} = name;
        beat.address               = addr;
        return beat;
    endfunction

    function automatic t_in random_beat();
        logic [NAME_W-1:0] name;
        logic [ADDR_W-1:0] addr;
        int                pick;
        pick = $urandom_range(0, 99);
        addr = 16'($urandom_range(0, 65535));
        if (pick < 10 || known_names.size() == 0) begin
            name = random_name();
            known_names.push_back(name);
            return make_beat(OP_INSERT, name, addr);
        end
        name = known_names[$urandom_range(0, known_names.size() - 1)];
        if (pick < 20) begin
            return make_beat(OP_INSERT, name, addr);
        end else if (pick < 60) begin
            return make_beat(OP_LOOKUP, name, addr);
        end else if (pick < 75) begin
            name[$urandom_range(0, NAME_W - 1)] ^= 1'b1;
            return make_beat(OP_LOOKUP, name, addr);
        end
        return make_beat(OP_LOOKUP, random_name(), addr);
    endfunction

    task automatic send_beat(input t_in beat);
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    initial begin : stimulus
        t_in               beat_plan [$];
        logic [NAME_W-1:0] nine;
        logic [NAME_W-1:0] gapped;
        int                sent;
        int                burst;
        int                gap;
        int                b;
        nine   = text_name("symbolnam");
        gapped = text_name("ab");
        gapped[31:24] = "c";
        beat_plan.push_back(make_beat(OP_LOOKUP, '0, 16'h0000));
        beat_plan.push_back(make_beat(OP_INSERT, '0, 16'h0000));
        beat_plan.push_back(make_beat(OP_INSERT, '1, 16'hFFFF));
        beat_plan.push_back(make_beat(OP_LOOKUP, '1, 16'h1234));
        beat_plan.push_back(make_beat(OP_LOOKUP, '0, 16'hFFFF));
        beat_plan.push_back(make_beat(OP_INSERT, '1, 16'h0000));
        beat_plan.push_back(make_beat(OP_INSERT, text_name("ab"), 16'h0101));
        beat_plan.push_back(make_beat(OP_INSERT, gapped, 16'h0202));
        beat_plan.push_back(make_beat(OP_LOOKUP, text_name("ab"), 16'h0000));
        beat_plan.push_back(make_beat(OP_LOOKUP, gapped, 16'h0000));
        beat_plan.push_back(make_beat(OP_INSERT, nine, 16'hA5A5));
        beat_plan.push_back(make_beat(OP_LOOKUP, nine ^ {8'h01, 64'h0}, 16'h0000));
        beat_plan.push_back(make_beat(OP_LOOKUP, nine, 16'h5A5A));
        beat_plan.push_back(make_beat(OP_LOOKUP, {8'hFF, 64'h0}, 16'h0000));
        beat_plan.push_back(make_beat(OP_INSERT, {8'h80, 64'h0}, 16'h8000));
        beat_plan.push_back(make_beat(OP_LOOKUP, {8'hFF, 64'h7FFF_FFFF_FFFF_FFFF},
                                      16'h0000));
        beat_plan.push_back(make_beat(OP_INSERT, text_name("x"), 16'h7FFF));
        beat_plan.push_back(make_beat(OP_LOOKUP, text_name("x"), 16'h0000));
        beat_plan.push_back(make_beat(OP_INSERT, text_name("x"), 16'h0001));
        known_names.push_back('0);
        known_names.push_back('1);
        known_names.push_back(text_name("ab"));
        known_names.push_back(gapped);
        known_names.push_back(nine);
        known_names.push_back({8'h80, 64'h0});
        known_names.push_back(text_name("x"));

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        sent = 0;
        while (sent < TOTAL_BEATS) begin
            burst = $urandom_range(1, 24);
            for (b = 0; b < burst && sent < TOTAL_BEATS; b++) begin
                send_beat((sent < beat_plan.size()) ? beat_plan[sent] : random_beat());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("symbol_table_insert_lookup regression: pass");
        end else begin
            $display("symbol_table_insert_lookup regression: fail");
        end
        $finish;
    end

    initial begin : sink_pattern
        t_sink_mode mode;
        int         seg;
        int         span;
        int         k;
        wait (i_rst_n === 1'b1);
        seg = 0;
        forever begin
            if (seg % 25 == 4) begin
                mode = SINK_HOLD;
                span = LONG_HOLD;
            end else begin
                mode = t_sink_mode'($urandom_range(0, 3));
                span = $urandom_range(10, 150);
            end
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (mode)
                    SINK_FREE: begin
                        i_ready <= 1'b1;
                    end
                    SINK_COIN: begin
                        i_ready <= ($urandom_range(0, 1) == 1);
                    end
                    SINK_PERIODIC: begin
                        i_ready <= ((k % 5) != 4);
                    end
                    SINK_SPARSE: begin
                        i_ready <= ($urandom_range(0, 7) == 0);
                    end
                    default: begin
                        i_ready <= 1'b0;
                    end
                endcase
            end
            seg++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("symbol_table_insert_lookup regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
